/* hw/rtl/arnw_pkg.sv */
// arnw_pkg: shared types and constants for the adaptive network rewiring step
// request and result structs, microcode word layout, sequencer enums
// no dependencies
package arnw_pkg;

  localparam int unsigned MAX_NODES  = 32;
  localparam int unsigned NODE_W     = 5;
  localparam int unsigned COUNT_W    = 6;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned PROB_W     = 17;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = COUNT_W'(MAX_NODES);
  localparam logic [COUNT_W-1:0] NODE_COUNT_MAX   = COUNT_W'(MAX_NODES);
  localparam logic [COUNT_W-1:0] NODE_COUNT_MIN   = COUNT_W'(2);

  typedef logic [MAX_NODES-1:0] row_t;

  typedef enum logic [1:0] {
    REQ_DRAW   = 2'd0,
    REQ_ALWAYS = 2'd1,
    REQ_NEVER  = 2'd2,
    REQ_UNUSED = 2'd3
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_COUNT  = 1'b0,
    CFG_REWIRE_PROB = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [NODE_W-1:0] focal_node;
    logic [NODE_W-1:0] other_draw;
    logic [FRAC_W-1:0] random_fraction;
  } req_t;

  typedef struct packed {
    logic [NODE_W-1:0] edge_low;
    logic [NODE_W-1:0] edge_high;
    logic              edge_added;
    logic              last;
  } res_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_CHECK,
    ACT_REMOVE,
    ACT_LOAD_J,
    ACT_ADD,
    ACT_LINK
  } action_e;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NO_START,
    COND_SKIP,
    COND_K_MORE,
    COND_NO_REWIRE
  } cond_e;

  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_CHECK,
    STEP_REMOVE,
    STEP_LOAD_J,
    STEP_ADD,
    STEP_LINK
  } step_e;

  typedef struct packed {
    action_e action;
    cond_e   cond;
    step_e   target;
  } ucode_t;

  typedef struct packed {
    action_e action;
    logic    busy;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic skip;
    logic k_more;
    logic no_rewire;
  } status_t;

endpackage

/* hw/rtl/arnw_seq.sv */
// arnw_seq: microcoded sequencer, step counter with control word rom
// depends on arnw_pkg
module arnw_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  arnw_pkg::status_t status_i,
  output arnw_pkg::ctrl_t   ctrl_o
);

  function automatic arnw_pkg::ucode_t ucode_rom(arnw_pkg::step_e step);
    arnw_pkg::ucode_t w;
    case (step)
      arnw_pkg::STEP_IDLE:
        w = '{arnw_pkg::ACT_NONE, arnw_pkg::COND_NO_START, arnw_pkg::STEP_IDLE};
      arnw_pkg::STEP_CHECK:
        w = '{arnw_pkg::ACT_CHECK, arnw_pkg::COND_SKIP, arnw_pkg::STEP_IDLE};
      arnw_pkg::STEP_REMOVE:
        w = '{arnw_pkg::ACT_REMOVE, arnw_pkg::COND_K_MORE, arnw_pkg::STEP_REMOVE};
      arnw_pkg::STEP_LOAD_J:
        w = '{arnw_pkg::ACT_LOAD_J, arnw_pkg::COND_NO_REWIRE, arnw_pkg::STEP_IDLE};
      arnw_pkg::STEP_ADD:
        w = '{arnw_pkg::ACT_ADD, arnw_pkg::COND_K_MORE, arnw_pkg::STEP_ADD};
      arnw_pkg::STEP_LINK:
        w = '{arnw_pkg::ACT_LINK, arnw_pkg::COND_ALWAYS, arnw_pkg::STEP_IDLE};
      default:
        w = '{arnw_pkg::ACT_NONE, arnw_pkg::COND_ALWAYS, arnw_pkg::STEP_IDLE};
    endcase
    return w;
  endfunction

  arnw_pkg::step_e  step_q, step_d;
  arnw_pkg::ucode_t word;
  logic             taken;

  assign word = ucode_rom(step_q);

  // next step
  always_comb begin
    case (word.cond)
      arnw_pkg::COND_ALWAYS:    taken = 1'b1;
      arnw_pkg::COND_NO_START:  taken = !status_i.start;
      arnw_pkg::COND_SKIP:      taken = status_i.skip;
      arnw_pkg::COND_K_MORE:    taken = status_i.k_more;
      arnw_pkg::COND_NO_REWIRE: taken = status_i.no_rewire;
      default:                  taken = 1'b1;
    endcase
    step_d = taken ? word.target : arnw_pkg::step_e'(3'(step_q + 3'd1));
  end

  // outputs
  always_comb begin
    ctrl_o.action = word.action;
    ctrl_o.busy   = (step_q != arnw_pkg::STEP_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= arnw_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

/* hw/rtl/adaptive_network_rewire_step.sv */
// adaptive_network_rewire_step: top level, adjacency matrix and edge datapath
// depends on arnw_pkg and arnw_seq
//
// An event is taken when start is high and busy low. Every edge change is shown on res_o for
// one cycle with res_valid_o; the receiver cannot stall, so results leave as they are made,
// at most one per cycle, the event's final one flagged by last. The sequencer scans all 32
// neighbour positions one per cycle: a rewiring event is busy for check, 32 removal steps,
// load of the other node's row, 32 join steps, link; a non-rewiring one ends after the load,
// a rejected or skipped one after check. The next event may start in the cycle after busy
// falls. Reset clears the graph; configure only while idle, as the block does not check it.
module adaptive_network_rewire_step (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  arnw_pkg::req_t                      req_i,
  output logic                                res_valid_o,
  output arnw_pkg::res_t                      res_o,
  input  logic                                cfg_we_i,
  input  logic [arnw_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [arnw_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  arnw_pkg::ctrl_t   ctrl;
  arnw_pkg::status_t status;

  logic [arnw_pkg::COUNT_W-1:0] node_count_q;
  logic [arnw_pkg::PROB_W-1:0]  prob_q;
  arnw_pkg::req_t               req_q;
  arnw_pkg::row_t               adj_q [arnw_pkg::MAX_NODES];
  arnw_pkg::row_t               adj_d [arnw_pkg::MAX_NODES];
  arnw_pkg::row_t               mask_q, mask_d, rest, rd_row;
  logic [arnw_pkg::NODE_W-1:0]  k_q, k_d, fi, dr, j, other, rd_idx;
  logic                         rew_q, rew_d, rew_now, valid_draw;
  logic [arnw_pkg::COUNT_W-1:0] n_eff;
  logic                         emit, emit_added, emit_last;
  logic                         res_valid_q;
  arnw_pkg::res_t               res_q;
  logic                         accept;

  arnw_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  assign busy   = ctrl.busy;
  assign accept = start && !ctrl.busy;

  assign fi     = req_q.focal_node;
  assign dr     = req_q.other_draw;
  assign j      = (dr >= fi) ? arnw_pkg::NODE_W'(dr + 1'b1) : dr;
  assign rd_idx = (ctrl.action == arnw_pkg::ACT_LOAD_J) ? j : fi;
  assign rd_row = adj_q[rd_idx];
  assign rest   = mask_q & ~(arnw_pkg::row_t'(1) << k_q);

  // decision of the current request
  always_comb begin
    n_eff = (node_count_q > arnw_pkg::NODE_COUNT_MAX) ? arnw_pkg::NODE_COUNT_MAX
                                                      : node_count_q;
    valid_draw = (req_q.req_type != arnw_pkg::REQ_UNUSED)
              && (n_eff >= arnw_pkg::NODE_COUNT_MIN)
              && ({1'b0, fi} < n_eff)
              && ({1'b0, dr} < arnw_pkg::COUNT_W'(n_eff - 1'b1));
    rew_now = (req_q.req_type == arnw_pkg::REQ_ALWAYS)
           || ((req_q.req_type == arnw_pkg::REQ_DRAW)
               && ({1'b0, req_q.random_fraction} < prob_q));
    status.start     = start;
    status.skip      = !valid_draw || (rew_now && rd_row[j]);
    status.k_more    = (k_q != '1);
    status.no_rewire = !rew_q;
  end

  // edge emission
  always_comb begin
    emit       = 1'b0;
    emit_added = 1'b0;
    emit_last  = 1'b0;
    other      = k_q;
    case (ctrl.action)
      arnw_pkg::ACT_REMOVE: begin
        emit      = mask_q[k_q];
        emit_last = !rew_q && (rest == '0);
      end
      arnw_pkg::ACT_ADD: begin
        emit       = mask_q[k_q] && (k_q != fi);
        emit_added = 1'b1;
      end
      arnw_pkg::ACT_LINK: begin
        emit       = 1'b1;
        emit_added = 1'b1;
        emit_last  = 1'b1;
        other      = j;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // matrix and scan registers next values
  always_comb begin
    adj_d  = adj_q;
    mask_d = mask_q;
    k_d    = k_q;
    rew_d  = rew_q;
    case (ctrl.action)
      arnw_pkg::ACT_CHECK: begin
        mask_d = rd_row;
        k_d    = '0;
        rew_d  = rew_now;
      end
      arnw_pkg::ACT_REMOVE: begin
        if (emit) begin
          adj_d[fi][k_q] = 1'b0;
          adj_d[k_q][fi] = 1'b0;
        end
        mask_d = rest;
        k_d    = arnw_pkg::NODE_W'(k_q + 1'b1);
      end
      arnw_pkg::ACT_LOAD_J: begin
        mask_d = rd_row;
        k_d    = '0;
      end
      arnw_pkg::ACT_ADD: begin
        if (emit) begin
          adj_d[fi][k_q] = 1'b1;
          adj_d[k_q][fi] = 1'b1;
        end
        k_d = arnw_pkg::NODE_W'(k_q + 1'b1);
      end
      arnw_pkg::ACT_LINK: begin
        adj_d[fi][j] = 1'b1;
        adj_d[j][fi] = 1'b1;
      end
      default: begin
        k_d = k_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < arnw_pkg::MAX_NODES; n++) begin
        adj_q[n] <= '0;
      end
      k_q         <= '0;
      rew_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      adj_q       <= adj_d;
      k_q         <= k_d;
      rew_q       <= rew_d;
      res_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= arnw_pkg::NODE_COUNT_RESET;
      prob_q       <= '0;
    end else if (cfg_we_i) begin
      case (arnw_pkg::cfg_idx_e'(cfg_idx_i))
        arnw_pkg::CFG_NODE_COUNT:  node_count_q <= cfg_data_i[arnw_pkg::COUNT_W-1:0];
        arnw_pkg::CFG_REWIRE_PROB: prob_q       <= cfg_data_i[arnw_pkg::PROB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    if (accept) begin
      req_q <= req_i;
    end
    if (emit) begin
      res_q.edge_low   <= (other < fi) ? other : fi;
      res_q.edge_high  <= (other < fi) ? fi : other;
      res_q.edge_added <= emit_added;
      res_q.last       <= emit_last;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

/* hw/rtl/arnw_checker.sv */
// arnw_checker: port-level checks on the rewiring step, bound to the top level
// depends on arnw_pkg and adaptive_network_rewire_step
module arnw_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           res_valid_o,
  input arnw_pkg::res_t res_o
);

  // a taken request always occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request taken but block not busy");

  // results only come out of a running event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("result strobe without a running event");

  // edges are sorted pairs with no self loop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.edge_low < res_o.edge_high))
    else $error("edge pair not sorted");

  // nothing follows the final edge of an event straight away
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |=> !res_valid_o)
    else $error("result right after the last one");

endmodule

bind adaptive_network_rewire_step arnw_checker u_arnw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
